@@ hw/rtl/flocking_heading_update_macros.svh @@
// Assertion macros for the checker file of the heading update block.
`ifndef FLOCKING_HEADING_UPDATE_MACROS_SVH
`define FLOCKING_HEADING_UPDATE_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define FHU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that an expression never holds.
`define FHU_NEVER(lbl, expr, msg) \
  `FHU_ASSERT(lbl, !(expr), msg)

`endif

@@ hw/rtl/fhu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fhu_pkg
// Types and constants shared by the flocking heading update modules.
// ----------------------------------------------------------------------------
package fhu_pkg;

  localparam int CFG_AW      = 4;
  localparam int CFG_DW      = 32;
  localparam int IN_TDATA_W  = 216;
  localparam int OUT_TDATA_W = 200;
  localparam int OUT_TUSER_W = 2;
  localparam int MOVER_W     = 192;
  localparam int N_W         = 7;
  localparam int ACC_W       = 39;
  localparam int W_W         = 42;
  localparam int SQRT_STEPS  = 32;
  localparam int DIV_STEPS   = 46;

  localparam logic [1:0] REG_RADIUS_SQ = 2'd0;
  localparam logic [1:0] REG_LIMIT     = 2'd1;
  localparam logic [1:0] REG_BOUND     = 2'd2;

  localparam logic [30:0] RADIUS_SQ_RST = 31'd3932160;
  localparam logic [5:0]  LIMIT_RST     = 6'd10;
  localparam logic [30:0] BOUND_RST     = 31'd6553600;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_RD_SELF,
    OP_LATCH_SELF,
    OP_RD_NB,
    OP_DIFF,
    OP_SQ,
    OP_ACC,
    OP_COMBINE,
    OP_MAG,
    OP_SHR,
    OP_SHL,
    OP_ZERO_HEAD,
    OP_SQSUM,
    OP_SUM,
    OP_SQRT,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_STORE,
    OP_UPDATE,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   load;
    logic   run_start;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic en_k;
    logic scan_stop;
    logic n_zero;
    logic m_zero;
    logic m_high;
    logic m_low;
    logic sqrt_last;
    logic div_last;
    logic axis_last;
    logic k_last;
    logic out_free;
  } dp_stat_t;

  typedef struct packed {
    logic [30:0] radius_sq;
    logic [5:0]  limit;
    logic [30:0] bound;
  } cfg_t;

endpackage

@@ hw/rtl/fhu_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fhu_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module fhu_regs import fhu_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic       wr;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.radius_sq <= RADIUS_SQ_RST;
      cfg.limit     <= LIMIT_RST;
      cfg.bound     <= BOUND_RST;
    end else if (wr) begin
      case (idx)
        REG_RADIUS_SQ: cfg.radius_sq <= pwdata[30:0];
        REG_LIMIT:     cfg.limit     <= pwdata[5:0];
        REG_BOUND:     cfg.bound     <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_RADIUS_SQ: prdata = {1'b0, cfg.radius_sq};
      REG_LIMIT:     prdata = {26'd0, cfg.limit};
      REG_BOUND:     prdata = {1'b0, cfg.bound};
      default:       prdata = '0;
    endcase
  end

endmodule

@@ hw/rtl/fhu_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fhu_ctrl
// Sequencer that steps the datapath through load, scan, normalize and update.
// ----------------------------------------------------------------------------
module fhu_ctrl import fhu_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  input  logic     s_tuser,
  output logic     s_tready,
  input  dp_stat_t st,
  output dp_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_START, S_RD_SELF, S_LATCH, S_RD_NB, S_DIFF, S_SQ, S_ACC,
    S_COMBINE, S_MAG, S_NORM, S_SUM, S_SQRT, S_DIV_INIT, S_DIV_STEP,
    S_DIV_STORE, S_UPDATE, S_EMIT
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign accept = s_tvalid && s_tready;

  always_comb begin
    state_next    = state;
    cmd.load      = accept && !s_tuser;
    cmd.run_start = accept && s_tuser;
    cmd.op        = OP_NONE;
    case (state)
      S_IDLE:    if (cmd.run_start) state_next = S_START;
      S_START:   state_next = st.empty ? S_EMIT : S_RD_SELF;
      S_RD_SELF: begin
        cmd.op     = OP_RD_SELF;
        state_next = S_LATCH;
      end
      S_LATCH: begin
        cmd.op     = OP_LATCH_SELF;
        state_next = st.en_k ? S_RD_NB : S_EMIT;
      end
      S_RD_NB: begin
        cmd.op     = OP_RD_NB;
        state_next = S_DIFF;
      end
      S_DIFF: begin
        cmd.op     = OP_DIFF;
        state_next = S_SQ;
      end
      S_SQ: begin
        cmd.op     = OP_SQ;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.op     = OP_ACC;
        state_next = st.scan_stop ? S_COMBINE : S_RD_NB;
      end
      S_COMBINE: begin
        cmd.op     = OP_COMBINE;
        state_next = st.n_zero ? S_UPDATE : S_MAG;
      end
      S_MAG: begin
        cmd.op     = OP_MAG;
        state_next = S_NORM;
      end
      S_NORM: begin
        if (st.m_zero) begin
          cmd.op     = OP_ZERO_HEAD;
          state_next = S_UPDATE;
        end else if (st.m_high) begin
          cmd.op = OP_SHR;
        end else if (st.m_low) begin
          cmd.op = OP_SHL;
        end else begin
          cmd.op     = OP_SQSUM;
          state_next = S_SUM;
        end
      end
      S_SUM: begin
        cmd.op     = OP_SUM;
        state_next = S_SQRT;
      end
      S_SQRT: begin
        cmd.op = OP_SQRT;
        if (st.sqrt_last) state_next = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd.op     = OP_DIV_INIT;
        state_next = S_DIV_STEP;
      end
      S_DIV_STEP: begin
        cmd.op = OP_DIV_STEP;
        if (st.div_last) state_next = S_DIV_STORE;
      end
      S_DIV_STORE: begin
        cmd.op     = OP_DIV_STORE;
        state_next = st.axis_last ? S_UPDATE : S_DIV_INIT;
      end
      S_UPDATE: begin
        cmd.op     = OP_UPDATE;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.op     = OP_EMIT;
          state_next = (st.empty || st.k_last) ? S_IDLE : S_RD_SELF;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      s_tready <= 1'b0;
    end else begin
      state    <= state_next;
      s_tready <= (state_next == S_IDLE);
    end
  end

endmodule

@@ hw/rtl/fhu_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fhu_dp
// Mover table, neighbor accumulation, normalize, square root and divider.
// ----------------------------------------------------------------------------
module fhu_dp import fhu_pkg::*; #(
  parameter int MAX_MOVERS = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  dp_cmd_t                cmd,
  output dp_stat_t               st,
  input  cfg_t                   cfg,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic [OUT_TUSER_W-1:0] m_tuser,
  output logic                   m_tlast
);

  localparam int SLOT_W = (MAX_MOVERS > 1) ? $clog2(MAX_MOVERS) : 1;
  localparam int E_W    = SLOT_W + 1;

  // Mover table, one word per slot: pos x,y,z then heading x,y,z.
  logic [MOVER_W-1:0] mem [MAX_MOVERS];
  logic [MOVER_W-1:0] rd_data, wdata;
  logic [SLOT_W-1:0]  raddr, waddr;
  logic               we;
  logic               en [MAX_MOVERS];

  logic [SLOT_W-1:0] k, j;
  logic [E_W-1:0]    e_reg;
  logic              empty;

  logic signed [31:0] pk [3];
  logic signed [31:0] hk [3];
  logic signed [31:0] pj [3];
  logic signed [31:0] hj [3];
  logic [23:0]        dm [3];
  logic [47:0]        sq [3];
  logic               far, cand;
  logic signed [ACC_W-1:0] sh [3];
  logic signed [ACC_W-1:0] sp [3];
  logic [N_W-1:0]     n;
  logic signed [W_W-1:0] w [3];
  logic [W_W-1:0]     m [3];
  logic [59:0]        sq30 [3];
  logic [63:0]        sx, res, bitv;
  logic [4:0]         scnt;
  logic [32:0]        rem;
  logic [DIV_STEPS-1:0] q;
  logic [5:0]         dcnt;
  logic [1:0]         axis;

  // Input fields.
  logic [5:0]   in_slot;
  logic         in_en;
  logic [6:0]   in_start, in_end, e_clamp;
  logic         slot_ok;

  assign in_slot  = s_tdata[5:0];
  assign in_en    = s_tdata[6];
  assign in_start = s_tdata[205:199];
  assign in_end   = s_tdata[212:206];
  assign slot_ok  = {1'b0, in_slot} < 7'(MAX_MOVERS);
  assign e_clamp  = (in_end > 7'(MAX_MOVERS)) ? 7'(MAX_MOVERS) : in_end;

  // Combinational helpers.
  logic signed [32:0] dd [3];
  logic [32:0]        dmag [3];
  logic [49:0]        dsum;
  logic               near;
  logic [N_W-1:0]     n_inc;
  logic signed [W_W-1:0] w_calc [3];
  logic [63:0]        sq_try;
  logic [32:0]        rem2;
  logic [31:0]        len;
  logic [32:0]        pmag [3];
  logic signed [31:0] upd_h [3];
  logic signed [31:0] upd_p [3];

  assign len    = res[31:0];
  assign sq_try = res + bitv;
  assign rem2   = {rem[31:0], q[DIV_STEPS-1]};
  assign n_inc  = n + N_W'(1);
  assign dsum   = 50'(sq[0]) + 50'(sq[1]) + 50'(sq[2]);
  assign near   = cand && !far && (dsum <= {3'd0, cfg.radius_sq, 16'd0});

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dd[i]     = {rd_data[32*i+31], rd_data[32*i +: 32]} - {pk[i][31], pk[i]};
      dmag[i]   = dd[i][32] ? 33'(-dd[i]) : 33'(dd[i]);
      w_calc[i] = W_W'(sh[i]) + $signed({{(W_W-N_W){1'b0}}, n}) * W_W'(pk[i])
                  - W_W'(sp[i]);
      pmag[i]   = pk[i][31] ? 33'(-{pk[i][31], pk[i]}) : {1'b0, pk[i]};
      upd_h[i]  = (pmag[i] > {2'b0, cfg.bound}) ? -hk[i] : hk[i];
      upd_p[i]  = pk[i] + upd_h[i];
    end
  end

  // Status toward the sequencer.
  always_comb begin
    st.empty     = empty;
    st.en_k      = en[k];
    st.scan_stop = (near && ({1'b0, n_inc} > {2'b0, cfg.limit}))
                   || (j == SLOT_W'(MAX_MOVERS - 1));
    st.n_zero    = (n == '0);
    st.m_zero    = (m[0] == '0) && (m[1] == '0) && (m[2] == '0);
    st.m_high    = (|m[0][W_W-1:30]) || (|m[1][W_W-1:30]) || (|m[2][W_W-1:30]);
    st.m_low     = !((|m[0][W_W-1:29]) || (|m[1][W_W-1:29]) || (|m[2][W_W-1:29]));
    st.sqrt_last = (scnt == 5'(SQRT_STEPS - 1));
    st.div_last  = (dcnt == 6'(DIV_STEPS - 1));
    st.axis_last = (axis == 2'd2);
    st.k_last    = ((E_W'(k) + E_W'(1)) == e_reg);
    st.out_free  = !m_tvalid || m_tready;
  end

  // Table access: loads while idle, write-back of the updated mover during a run.
  assign raddr = (cmd.op == OP_RD_NB) ? j : k;
  assign we    = (cmd.load && slot_ok) || (cmd.op == OP_UPDATE);
  assign waddr = cmd.load ? in_slot[SLOT_W-1:0] : k;
  assign wdata = cmd.load ? s_tdata[198:7]
                          : {upd_h[2], upd_h[1], upd_h[0], upd_p[2], upd_p[1], upd_p[0]};

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_data <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_MOVERS; i++) en[i] <= 1'b0;
    end else if (cmd.load && slot_ok) begin
      en[in_slot[SLOT_W-1:0]] <= in_en;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      empty <= 1'b0;
    end else if (cmd.run_start) begin
      empty <= (in_start >= e_clamp);
      k     <= in_start[SLOT_W-1:0];
      e_reg <= e_clamp[E_W-1:0];
    end else begin
      case (cmd.op)
        OP_LATCH_SELF: begin
          for (int i = 0; i < 3; i++) begin
            pk[i] <= rd_data[32*i +: 32];
            hk[i] <= rd_data[96+32*i +: 32];
            sh[i] <= '0;
            sp[i] <= '0;
          end
          j <= '0;
          n <= '0;
        end
        OP_DIFF: begin
          for (int i = 0; i < 3; i++) begin
            pj[i] <= rd_data[32*i +: 32];
            hj[i] <= rd_data[96+32*i +: 32];
            dm[i] <= dmag[i][23:0];
          end
          far  <= (|dmag[0][32:24]) || (|dmag[1][32:24]) || (|dmag[2][32:24]);
          cand <= (j != k) && en[j];
        end
        OP_SQ: begin
          for (int i = 0; i < 3; i++) sq[i] <= dm[i] * dm[i];
        end
        OP_ACC: begin
          if (near) begin
            for (int i = 0; i < 3; i++) begin
              sh[i] <= sh[i] + ACC_W'(hj[i]);
              sp[i] <= sp[i] + ACC_W'(pj[i]);
            end
            n <= n_inc;
          end
          j <= j + SLOT_W'(1);
        end
        OP_COMBINE: begin
          for (int i = 0; i < 3; i++) w[i] <= w_calc[i];
        end
        OP_MAG: begin
          for (int i = 0; i < 3; i++) m[i] <= w[i][W_W-1] ? W_W'(-w[i]) : W_W'(w[i]);
        end
        OP_SHR: begin
          for (int i = 0; i < 3; i++) m[i] <= m[i] >> 1;
        end
        OP_SHL: begin
          for (int i = 0; i < 3; i++) m[i] <= m[i] << 1;
        end
        OP_ZERO_HEAD: begin
          for (int i = 0; i < 3; i++) hk[i] <= '0;
        end
        OP_SQSUM: begin
          for (int i = 0; i < 3; i++) sq30[i] <= m[i][29:0] * m[i][29:0];
        end
        OP_SUM: begin
          sx   <= 64'(sq30[0]) + 64'(sq30[1]) + 64'(sq30[2]);
          res  <= '0;
          bitv <= 64'h4000_0000_0000_0000;
          scnt <= '0;
          axis <= '0;
        end
        OP_SQRT: begin
          // One result bit per cycle of the digit-by-digit square root.
          if (sx >= sq_try) begin
            sx  <= sx - sq_try;
            res <= (res >> 1) + bitv;
          end else begin
            res <= res >> 1;
          end
          bitv <= bitv >> 2;
          scnt <= scnt + 5'd1;
        end
        OP_DIV_INIT: begin
          rem  <= '0;
          q    <= {m[axis][29:0], 16'd0};
          dcnt <= '0;
        end
        OP_DIV_STEP: begin
          // Restoring division; the quotient shifts in where the dividend leaves.
          if (rem2 >= {1'b0, len}) begin
            rem <= rem2 - {1'b0, len};
            q   <= {q[DIV_STEPS-2:0], 1'b1};
          end else begin
            rem <= rem2;
            q   <= {q[DIV_STEPS-2:0], 1'b0};
          end
          dcnt <= dcnt + 6'd1;
        end
        OP_DIV_STORE: begin
          hk[axis] <= w[axis][W_W-1] ? -$signed(q[31:0]) : $signed(q[31:0]);
          axis     <= axis + 2'd1;
        end
        OP_UPDATE: begin
          for (int i = 0; i < 3; i++) begin
            hk[i] <= upd_h[i];
            pk[i] <= upd_p[i];
          end
        end
        OP_EMIT: k <= k + SLOT_W'(1);
        default: ;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.op == OP_EMIT) begin
      m_tvalid <= 1'b1;
      if (empty) begin
        m_tdata <= '0;
        m_tuser <= 2'b10;
        m_tlast <= 1'b1;
      end else begin
        m_tuser <= {1'b0, en[k]};
        m_tlast <= st.k_last;
        if (en[k]) begin
          m_tdata <= {2'b00, pk[2], pk[1], pk[0], hk[2], hk[1], hk[0], 6'(k)};
        end else begin
          m_tdata <= {194'd0, 6'(k)};
        end
      end
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

@@ hw/rtl/flocking_heading_update.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flocking_heading_update
// Mover table with an in-place flocking heading and position update per run.
// ----------------------------------------------------------------------------
// Channel  Direction  Content
// s_*      in         load item (tuser 0) or run item (tuser 1)
// m_*      out        one result per slot of a run, tlast on the final one
// APB      in/out     three configuration registers at 0x0, 0x4, 0x8
//
// Loads are taken back to back while idle. A run visits the slots of its range
// in order; a disabled slot goes straight to the output, and for an enabled slot
// the neighbor search walks the table through its single read port, then the
// normalize shifts, square root and divider follow unless no neighbor was found.
// Reset is synchronous; the enabled bits clear at once, no clearing pass.
// The sequencer only stalls while the output register is still full.
module flocking_heading_update import fhu_pkg::*; #(
  parameter int MAX_MOVERS = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // slot[5:0], enabled[6], pos_x/y/z[102:7], head_x/y/z[198:103],
  // range_start[205:199], range_end[212:206]
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // req_type
  input  logic                   s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // out_slot[5:0], new_head_x/y/z[101:6], new_pos_x/y/z[197:102]
  output logic [OUT_TDATA_W-1:0] m_tdata,
  // moved[0], empty_run[1]
  output logic [OUT_TUSER_W-1:0] m_tuser,
  output logic                   m_tlast,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CFG_AW-1:0]      paddr,
  input  logic [CFG_DW-1:0]      pwdata,
  output logic [CFG_DW-1:0]      prdata,
  output logic                   pready
);

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t st;

  fhu_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  fhu_ctrl u_ctrl (
    .clk, .rst, .s_tvalid, .s_tuser, .s_tready, .st, .cmd
  );

  fhu_dp #(.MAX_MOVERS(MAX_MOVERS)) u_dp (
    .clk, .rst, .cmd, .st, .cfg, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
  );

endmodule

@@ hw/rtl/fhu_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fhu_checker
// Port-level checks of the flocking heading update block.
// ----------------------------------------------------------------------------
`include "flocking_heading_update_macros.svh"

module fhu_checker import fhu_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic [IN_TDATA_W-1:0]  s_tdata,
  input logic                   s_tuser,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata,
  input logic [OUT_TUSER_W-1:0] m_tuser,
  input logic                   m_tlast,
  input logic                   psel,
  input logic                   penable,
  input logic                   pwrite,
  input logic [CFG_AW-1:0]      paddr,
  input logic [CFG_DW-1:0]      pwdata,
  input logic [CFG_DW-1:0]      prdata,
  input logic                   pready
);

  // A stalled result holds.
  `FHU_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")
  // A run transaction closes the input once it is accepted.
  `FHU_ASSERT(a_run_blocks, s_tvalid && s_tready && s_tuser |=> !s_tready, "input open during run")
  // An empty run reports nothing but its flag and the end mark.
  `FHU_ASSERT(a_empty_run, m_tvalid && m_tuser[1] |-> m_tlast && !m_tuser[0] && m_tdata == '0, "bad empty-run result")
  // A slot that did not move reports zero heading and position.
  `FHU_ASSERT(a_still_zero, m_tvalid && !m_tuser[0] |-> m_tdata[197:6] == '0, "unmoved slot has data")

endmodule

bind flocking_heading_update fhu_checker u_fhu_checker (.*);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives load and run transactions into the flocking heading update block,
// writes its registers between phases, predicts every result from its own
// copy of the mover table and checks the results in order, field by field.
// ----------------------------------------------------------------------------
module testbench;
  import fhu_pkg::*;

  localparam int NUM_SLOTS = 64;
  localparam int CYCLE_LIMIT = 40000000;

  typedef struct packed {
    bit             is_run;
    bit [5:0]       slot;
    bit             enabled;
    bit [2:0][31:0] pos;
    bit [2:0][31:0] head;
    bit [6:0]       range_start;
    bit [6:0]       range_end;
  } mover_req_t;

  typedef struct packed {
    bit [5:0]       slot;
    bit             moved;
    bit             empty_run;
    bit [2:0][31:0] head;
    bit [2:0][31:0] pos;
    bit             last;
  } mover_result_t;

  class flock_scoreboard;
    bit             enabled[NUM_SLOTS];
    bit [2:0][31:0] pos[NUM_SLOTS];
    bit [2:0][31:0] head[NUM_SLOTS];
    bit [30:0]      radius_sq = RADIUS_SQ_RST;
    bit [5:0]       nb_limit = LIMIT_RST;
    bit [30:0]      bound = BOUND_RST;
    mover_result_t  expected_q[$];
    int             errors;

    function longint sx(bit [31:0] v);
      return longint'(signed'(v));
    endfunction

    function bit [63:0] mag(longint v);
      return v < 0 ? -v : v;
    endfunction

    function bit is_near(int a, int b);
      bit [63:0] acc;
      bit [63:0] m;
      acc = 0;
      for (int i = 0; i < 3; i++) begin
        m = mag(sx(pos[b][i]) - sx(pos[a][i]));
        if (m >= (64'd1 << 24)) return 0;
        acc += m * m;
      end
      return acc <= ({33'd0, radius_sq} << 16);
    endfunction

    function bit [63:0] int_sqrt(bit [63:0] x);
      bit [63:0] root;
      bit [63:0] b;
      root = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= root + b) begin
          x -= root + b;
          root = (root >> 1) + b;
        end else begin
          root >>= 1;
        end
        b >>= 2;
      end
      return root;
    endfunction

    // Scale the vector so its largest axis lies in [2^29, 2^30), then divide
    // each axis, shifted left by 16, by the integer length.
    function bit [2:0][31:0] unit_heading(longint w[3]);
      bit [63:0]      m[3];
      bit [63:0]      mx;
      bit [63:0]      len;
      bit [63:0]      q;
      bit [2:0][31:0] r;
      mx = 0;
      r = '0;
      for (int i = 0; i < 3; i++) begin
        m[i] = mag(w[i]);
        if (m[i] > mx) mx = m[i];
      end
      if (mx == 0) return r;
      while (mx >= (64'd1 << 30)) begin
        mx >>= 1;
        for (int i = 0; i < 3; i++) m[i] >>= 1;
      end
      while (mx < (64'd1 << 29)) begin
        mx <<= 1;
        for (int i = 0; i < 3; i++) m[i] <<= 1;
      end
      len = int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
      for (int i = 0; i < 3; i++) begin
        q = (m[i] << 16) / len;
        r[i] = w[i] < 0 ? 32'(-q) : q[31:0];
      end
      return r;
    endfunction

    function void move_one(int k);
      longint sum_h[3];
      longint sum_p[3];
      longint p[3];
      longint w[3];
      int     n;
      n = 0;
      for (int i = 0; i < 3; i++) begin
        sum_h[i] = 0;
        sum_p[i] = 0;
        p[i] = sx(pos[k][i]);
      end
      for (int j = 0; j < NUM_SLOTS; j++) begin
        if (j == k || !enabled[j] || !is_near(k, j)) continue;
        for (int i = 0; i < 3; i++) begin
          sum_h[i] += sx(head[j][i]);
          sum_p[i] += sx(pos[j][i]);
        end
        n++;
        if (n > nb_limit) break;
      end
      if (n > 0) begin
        for (int i = 0; i < 3; i++) w[i] = sum_h[i] + longint'(n) * p[i] - sum_p[i];
        head[k] = unit_heading(w);
      end
      for (int i = 0; i < 3; i++) begin
        if (mag(p[i]) > {33'd0, bound}) head[k][i] = -head[k][i];
        pos[k][i] = pos[k][i] + head[k][i];
      end
    endfunction

    function void note_request(mover_req_t req);
      mover_result_t res;
      int            first;
      int            stop;
      if (!req.is_run) begin
        enabled[req.slot] = req.enabled;
        pos[req.slot] = req.pos;
        head[req.slot] = req.head;
        return;
      end
      first = req.range_start;
      stop = req.range_end > NUM_SLOTS ? NUM_SLOTS : req.range_end;
      if (first >= stop) begin
        res = '0;
        res.empty_run = 1;
        res.last = 1;
        expected_q.push_back(res);
        return;
      end
      for (int k = first; k < stop; k++) begin
        res = '0;
        res.slot = 6'(k);
        if (enabled[k]) begin
          move_one(k);
          res.moved = 1;
          res.head = head[k];
          res.pos = pos[k];
        end
        res.last = (k + 1 == stop);
        expected_q.push_back(res);
      end
    endfunction

    function void check_result(mover_result_t got);
      mover_result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.slot != want.slot) begin
        $display("%0t: out_slot expected %0d actual %0d", $time, want.slot, got.slot);
        errors++;
      end
      if (got.moved != want.moved) begin
        $display("%0t: moved expected %0d actual %0d", $time, want.moved, got.moved);
        errors++;
      end
      if (got.empty_run != want.empty_run) begin
        $display("%0t: empty_run expected %0d actual %0d", $time, want.empty_run,
                 got.empty_run);
        errors++;
      end
      if (got.head != want.head) begin
        $display("%0t: slot %0d heading expected %h actual %h", $time, want.slot,
                 want.head, got.head);
        errors++;
      end
      if (got.pos != want.pos) begin
        $display("%0t: slot %0d position expected %h actual %h", $time, want.slot,
                 want.pos, got.pos);
        errors++;
      end
      if (got.last != want.last) begin
        $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic                   clk = 0;
  logic                   rst = 1;
  logic                   s_tvalid = 0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   s_tuser = 0;
  logic                   m_tvalid;
  logic                   m_tready = 0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [OUT_TUSER_W-1:0] m_tuser;
  logic                   m_tlast;
  logic                   psel = 0;
  logic                   penable = 0;
  logic                   pwrite = 0;
  logic [CFG_AW-1:0]      paddr = '0;
  logic [CFG_DW-1:0]      pwdata = '0;
  logic [CFG_DW-1:0]      prdata;
  logic                   pready;

  flock_scoreboard sb = new();
  int              send_idle_pct = 0;
  int              stall_pct = 0;
  int unsigned     cycle_count = 0;

  flocking_heading_update dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) m_tready <= 0;
    else m_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    mover_result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.slot = m_tdata[5:0];
      got.moved = m_tuser[0];
      got.empty_run = m_tuser[1];
      for (int i = 0; i < 3; i++) begin
        got.head[i] = m_tdata[6 + 32 * i +: 32];
        got.pos[i] = m_tdata[102 + 32 * i +: 32];
      end
      got.last = m_tlast;
      sb.check_result(got);
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] value);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= CFG_AW'(idx) << 2;
    pwdata <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    @(posedge clk);
    psel <= 1;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    if (prdata != value) begin
      $display("%0t: register %0d expected %h actual %h", $time, idx, value, prdata);
      sb.errors++;
    end
    psel <= 0;
    penable <= 0;
    case (idx)
      REG_RADIUS_SQ: sb.radius_sq = value[30:0];
      REG_LIMIT:     sb.nb_limit = value[5:0];
      default:       sb.bound = value[30:0];
    endcase
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic send(mover_req_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= req.is_run;
    s_tdata <= {3'b0, req.range_end, req.range_start, req.head, req.pos, req.enabled,
                req.slot};
    do @(posedge clk); while (!s_tready);
    sb.note_request(req);
  endtask

  function automatic mover_req_t load_req(int slot, bit en, bit [2:0][31:0] p,
                                          bit [2:0][31:0] h);
    mover_req_t req;
    req = '0;
    req.slot = 6'(slot);
    req.enabled = en;
    req.pos = p;
    req.head = h;
    return req;
  endfunction

  function automatic mover_req_t run_req(int first, int stop);
    mover_req_t req;
    req = '0;
    req.is_run = 1;
    req.range_start = 7'(first);
    req.range_end = 7'(stop);
    return req;
  endfunction

  // Most movers sit in a small cluster so they find neighbors; some sit past
  // the default bound and a few take fully random values.
  function automatic bit [31:0] rand_coord();
    int sel;
    sel = $urandom_range(99);
    if (sel < 70) return $urandom_range(1048576) - 524288;
    if (sel < 85) return ($urandom_range(1) ? 1 : -1) * int'($urandom_range(6553600, 7300000));
    return $urandom;
  endfunction

  function automatic mover_req_t rand_req();
    mover_req_t req;
    int         sel;
    int         first;
    req = '0;
    sel = $urandom_range(99);
    if (sel < 68) begin
      req.slot = 6'($urandom_range(99) < 80 ? $urandom_range(15) : $urandom_range(63));
      req.enabled = $urandom_range(99) < 80;
      for (int i = 0; i < 3; i++) begin
        req.pos[i] = rand_coord();
        req.head[i] = $urandom_range(99) < 85 ? $urandom_range(262144) - 131072 : $urandom;
      end
    end else if (sel < 93) begin
      first = $urandom_range(15);
      req = run_req(first, first + $urandom_range(6));
    end else if (sel < 96) begin
      req = run_req(0, NUM_SLOTS);
    end else begin
      req = run_req($urandom_range(NUM_SLOTS), $urandom_range(NUM_SLOTS));
    end
    return req;
  endfunction

  initial begin
    logic [30:0] radius_set[5] = '{31'd3932160, 31'h7FFFFFFF, 31'd0, 31'd500000,
                                   31'd3932160};
    logic [5:0]  limit_set[5] = '{6'd10, 6'd0, 6'd63, 6'd3, 6'd10};
    logic [30:0] bound_set[5] = '{31'd6553600, 31'd0, 31'h7FFFFFFF, 31'd300000,
                                  31'd6553600};
    int          idle_set[5] = '{0, 85, 0, 20, 0};
    int          stall_set[5] = '{0, 0, 85, 20, 0};

    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    for (int ph = 0; ph < 5; ph++) begin
      wait_drained();
      reg_write(REG_RADIUS_SQ, {1'b0, radius_set[ph]});
      reg_write(REG_LIMIT, {26'd0, limit_set[ph]});
      reg_write(REG_BOUND, {1'b0, bound_set[ph]});
      send_idle_pct = idle_set[ph];
      stall_pct = stall_set[ph];

      if (ph == 0) begin
        send(run_req(5, 5));
        send(run_req(NUM_SLOTS, NUM_SLOTS));
        send(run_req(10, 3));
        send(run_req(0, 4));
        send(load_req(0, 1, {32'h0003_0000, 32'h0002_0000, 32'h0001_0000},
                      {32'h0, 32'h0, 32'h0001_0000}));
        send(load_req(1, 1, {32'h0003_8000, 32'hFFFF_0000, 32'h0002_0000},
                      {32'h0000_4000, 32'h0001_0000, 32'hFFFF_8000}));
        // Two movers at one point with zero headings give a zero vector.
        send(load_req(5, 1, {32'h0020_0000, 32'h0020_0000, 32'h0020_0000}, '0));
        send(load_req(6, 1, {32'h0020_0000, 32'h0020_0000, 32'h0020_0000}, '0));
        send(load_req(2, 0, {32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
                      {32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}));
        // Past the bound with the most negative heading: negation wraps.
        send(load_req(63, 1, {32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF},
                      {32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000}));
        send(load_req(62, 1, {32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000},
                      {32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF}));
        send(run_req(0, 7));
        send(run_req(60, NUM_SLOTS));
        send(run_req(0, NUM_SLOTS));
        send(load_req(5, 0, '0, '0));
        send(run_req(4, 7));
      end

      for (int n = 0; n < 36; n++) begin
        if (ph == 1 && n == 18) begin
          s_tvalid <= 0;
          while (sb.expected_q.size() != 0) @(posedge clk);
        end
        send(rand_req());
      end
      s_tvalid <= 0;
    end

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (1000) @(posedge clk);
    if (sb.errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end
endmodule
